[hdl/ict_pkg.sv]
// ----------------------------------------------------------------------------
// ict_pkg
// Shared types and constants for the interval cover tracker.
// ----------------------------------------------------------------------------
package ict_pkg;

  localparam int MAX_SPANS_DEF = 16;

  localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;

  localparam logic [1:0] OP_COVER = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic REG_MIN_BOUND = 1'b0;
  localparam logic REG_MAX_BOUND = 1'b1;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [63:0] span_start;
    logic signed [63:0] span_end;
    logic signed [63:0] query_value;
  } in_item_t;

  typedef struct packed {
    logic               covered;
    logic               fully_covered;
    logic signed [63:0] uncovered_low;
    logic signed [63:0] uncovered_high;
    logic [4:0]         span_total;
    logic               table_full;
  } out_item_t;

  // per cell compare results
  typedef struct packed {
    logic below;
    logic touch;
    logic hit;
  } cell_flags_t;

endpackage

[hdl/ict_cell.sv]
// ----------------------------------------------------------------------------
// ict_cell
// One table entry: holds a span in offset form and compares it with the item.
// ----------------------------------------------------------------------------
module ict_cell
  import ict_pkg::*;
(
  input  logic        clk,
  input  logic        valid,
  input  logic [63:0] new_first,
  input  logic [63:0] new_last,
  input  logic [63:0] query,
  input  logic        load_en,
  input  logic [63:0] load_first,
  input  logic [63:0] load_last,
  output logic [63:0] first,
  output logic [63:0] last,
  output cell_flags_t flags
);

  logic [63:0] first_r;
  logic [63:0] last_r;
  logic        gap_before;
  logic        gap_after;

  // 65-bit compares so that +1 never wraps
  assign gap_before = {1'b0, new_first} > ({1'b0, last_r} + 65'd1);
  assign gap_after  = {1'b0, first_r} > ({1'b0, new_last} + 65'd1);

  assign flags.below  = valid && gap_before;
  assign flags.touch  = valid && !gap_before && !gap_after;
  assign flags.hit    = valid && (query >= first_r) && (query <= last_r);

  assign first = first_r;
  assign last  = last_r;

  always_ff @(posedge clk) begin
    if (load_en) begin
      first_r <= load_first;
      last_r  <= load_last;
    end
  end

endmodule

[hdl/interval_cover_tracker.sv]
// ----------------------------------------------------------------------------
// interval_cover_tracker
// Sorted table of disjoint signed 64-bit spans with cover, query and clear.
// ----------------------------------------------------------------------------
// usage
//   in_valid/in_data/in_stall carry one item (op, span, query value); a
//   transfer happens when in_valid is high and in_stall low
//   out_valid/out_data/out_stall return exactly one result per item
//   cfg_we/cfg_index/cfg_wdata write min_bound (0) or max_bound (1), idle only
// sequence
//   a cover item with a non-empty clamped span passes clamp, compare, merge
//   and reload of the cell row, then result build; other items skip the merge;
//   one item in flight: no new item is taken until its result is loaded
// reset
//   rst_n low empties the table, sets full-range bounds and drops any
//   pending result; stored spans themselves are not cleared
// stall
//   a finished result waits in the output register; the sequencer holds
//   its next result until that register is free, in_stall stays high
// ----------------------------------------------------------------------------
module interval_cover_tracker
  import ict_pkg::*;
#(
  parameter int MAX_SPANS = MAX_SPANS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  in_item_t   in_data,
  output logic       in_stall,
  output logic       out_valid,
  output out_item_t  out_data,
  input  logic       out_stall,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [63:0] cfg_wdata
);

  localparam int CW = $clog2(MAX_SPANS + 1);
  localparam int IW = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_CLAMP, S_CMP, S_MERGE, S_RES
  } state_t;

  state_t      state_r;
  // bounds in offset form (sign bit flipped)
  logic [63:0] min_r;
  logic [63:0] max_r;
  logic [CW-1:0] used_r;

  in_item_t    item_r;
  logic [63:0] s_r;
  logic [63:0] e_r;
  logic        empty_r;
  logic        covered_r;
  logic        dropped_r;
  logic [MAX_SPANS-1:0] below_r;
  logic [MAX_SPANS-1:0] touch_r;
  logic [CW-1:0] b_r;
  logic [CW-1:0] a_r;

  logic        out_valid_r;
  out_item_t   out_data_r;

  // cell row wires
  logic [63:0]     cell_first [MAX_SPANS];
  logic [63:0]     cell_last  [MAX_SPANS];
  cell_flags_t     cell_flags [MAX_SPANS];
  logic [MAX_SPANS-1:0] cell_valid;
  logic [MAX_SPANS-1:0] load_en;
  logic [63:0]     load_first [MAX_SPANS];
  logic [63:0]     load_last  [MAX_SPANS];

  // effective bounds
  logic [63:0] hi;
  logic [63:0] lo;
  assign hi = max_r;
  assign lo = (min_r > max_r) ? max_r : min_r;

  // item operands in offset form
  logic [63:0] raw_s;
  logic [63:0] raw_e;
  logic [63:0] q_off;
  assign raw_s = item_r.span_start ^ SIGN_BIT;
  assign raw_e = item_r.span_end ^ SIGN_BIT;
  assign q_off = item_r.query_value ^ SIGN_BIT;

  logic [63:0] s_clamp;
  logic [63:0] e_clamp;
  assign s_clamp = (raw_s < lo) ? lo : ((raw_s > hi) ? hi : raw_s);
  assign e_clamp = (raw_e < lo) ? lo : ((raw_e > hi) ? hi : raw_e);

  genvar g;
  generate
    for (g = 0; g < MAX_SPANS; g++) begin : g_cell
      assign cell_valid[g] = (CW'(g) < used_r);
      ict_cell u_cell (
        .clk        (clk),
        .valid      (cell_valid[g]),
        .new_first  (s_r),
        .new_last   (e_r),
        .query      (q_off),
        .load_en    (load_en[g]),
        .load_first (load_first[g]),
        .load_last  (load_last[g]),
        .first      (cell_first[g]),
        .last       (cell_last[g]),
        .flags      (cell_flags[g])
      );
    end
  endgenerate

  // flag counts for the compare step
  logic [CW-1:0] b_cnt;
  logic [CW-1:0] a_cnt;
  logic          hit_any;
  always_comb begin
    b_cnt   = '0;
    a_cnt   = '0;
    hit_any = 1'b0;
    for (int j = 0; j < MAX_SPANS; j++) begin
      b_cnt   = b_cnt + CW'(cell_flags[j].below);
      a_cnt   = a_cnt + CW'(cell_flags[j].touch);
      hit_any = hit_any | cell_flags[j].hit;
    end
  end

  // merge: touching spans form one run, pick its ends
  logic [63:0] run_first;
  logic [63:0] run_last;
  logic [63:0] ms;
  logic [63:0] me;
  logic        drop;
  logic [CW:0] new_used;
  always_comb begin
    run_first = '0;
    run_last  = '0;
    for (int j = 0; j < MAX_SPANS; j++) begin
      if (touch_r[j] && (j == 0 || !touch_r[(j == 0) ? 0 : j - 1]))
        run_first = run_first | cell_first[j];
      if (touch_r[j] && (j == MAX_SPANS - 1 || !touch_r[(j == MAX_SPANS - 1) ? j : j + 1]))
        run_last = run_last | cell_last[j];
    end
    ms = (a_r != '0 && run_first < s_r) ? run_first : s_r;
    me = (a_r != '0 && run_last > e_r) ? run_last : e_r;
    new_used = {1'b0, used_r} + (CW + 1)'(1) - {1'b0, a_r};
    drop = new_used > (CW + 1)'(MAX_SPANS);
  end

  // reload of the cell row: spans after the run move by 1 - a
  always_comb begin
    for (int j = 0; j < MAX_SPANS; j++) begin
      load_en[j]    = 1'b0;
      load_first[j] = ms;
      load_last[j]  = me;
      if (state_r == S_MERGE && item_r.op == OP_COVER && !empty_r && !drop) begin
        if (j == int'(b_r)) begin
          load_en[j] = 1'b1;
        end else if (j > int'(b_r)) begin
          load_en[j] = 1'b1;
          for (int k = 0; k < MAX_SPANS; k++) begin
            if (k == j - 1 + int'(a_r)) begin
              load_first[j] = cell_first[k];
              load_last[j]  = cell_last[k];
            end
          end
        end
      end
    end
  end

  // result build from the current table
  logic [IW-1:0] last_idx;
  logic [63:0]   f0;
  logic [63:0]   l0;
  logic [63:0]   fl;
  logic [63:0]   ll;
  logic [63:0]   low_res;
  logic [63:0]   high_res;
  logic          full;
  logic [31:0]   used32;
  out_item_t     res;
  always_comb begin
    last_idx = IW'(used_r - CW'(1));
    f0 = cell_first[0];
    l0 = cell_last[0];
    fl = cell_first[last_idx];
    ll = cell_last[last_idx];
    low_res  = lo;
    high_res = hi;
    full = (used_r == CW'(1)) && (f0 <= lo) && (l0 >= hi);
    if (used_r != '0) begin
      if (f0 <= lo)
        low_res = (l0 >= hi) ? hi : l0 + 64'd1;
      if (ll >= hi)
        high_res = (fl <= lo) ? lo : fl - 64'd1;
    end
    used32 = 32'(used_r);
    res.covered        = covered_r;
    res.fully_covered  = full;
    res.uncovered_low  = low_res ^ SIGN_BIT;
    res.uncovered_high = high_res ^ SIGN_BIT;
    res.span_total     = used32[4:0];
    res.table_full     = dropped_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      min_r       <= '0;
      max_r       <= '1;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_MIN_BOUND) min_r <= cfg_wdata ^ SIGN_BIT;
        else                            max_r <= cfg_wdata ^ SIGN_BIT;
      end
      // the result step owns the output valid while it is active
      if (out_valid_r && !out_stall && state_r != S_RES) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            item_r  <= in_data;
            state_r <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          s_r       <= s_clamp;
          e_r       <= e_clamp;
          empty_r   <= s_clamp > e_clamp;
          covered_r <= 1'b0;
          dropped_r <= 1'b0;
          state_r   <= S_CMP;
        end
        S_CMP: begin
          for (int j = 0; j < MAX_SPANS; j++) begin
            below_r[j] <= cell_flags[j].below;
            touch_r[j] <= cell_flags[j].touch;
          end
          b_r <= b_cnt;
          a_r <= a_cnt;
          if (item_r.op == OP_QUERY) covered_r <= hit_any;
          if (item_r.op == OP_CLEAR) used_r <= '0;
          state_r <= (item_r.op == OP_COVER && !empty_r) ? S_MERGE : S_RES;
        end
        S_MERGE: begin
          if (drop) dropped_r <= 1'b1;
          else      used_r    <= CW'(new_used);
          state_r <= S_RES;
        end
        S_RES: begin
          if (!out_valid_r || !out_stall) begin
            out_data_r  <= res;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  // table count never passes the cell row
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(MAX_SPANS))
    else $error("span count beyond cell row");

  // a new result only comes out of the result step
  a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RES))
    else $error("result without result step");

  // a dropped span leaves the count unchanged
  a_drop_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MERGE && drop) |=> $stable(used_r))
    else $error("dropped span changed the table");

  // when spans lie below the run, cell 0 is one of them
  a_below_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MERGE && b_r != '0) |-> below_r[0])
    else $error("span order broken");
`endif

endmodule
